FILE: sv/banked_tile_ram_attribute_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the banked tile RAM attribute decoder
// Each macro places one labeled concurrent assertion that is clocked on clk
// and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BANKED_TILE_RAM_ATTRIBUTE_DECODER_TOP_ASSERT_SVH
`define BANKED_TILE_RAM_ATTRIBUTE_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTRAD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTRAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/btrad_pkg.sv
// ----------------------------------------------------------------------------
// Banked tile RAM attribute decoder package
// Request codes, field widths and the types shared by the top level and the
// attribute decoder.
// ----------------------------------------------------------------------------
package btrad_pkg;

	localparam int OpWidth    = 3;
	localparam int AddrWidth  = 11;
	localparam int ByteWidth  = 8;
	localparam int TileWidth  = 10;
	localparam int CodeWidth  = 7;
	localparam int ColorWidth = 3;
	localparam int RamAddrWidth = AddrWidth + 1;
	localparam int RamDepth   = 1 << RamAddrWidth;

	localparam int InWidth  = 40;
	localparam int OutWidth = 32;

	localparam logic [OpWidth-1:0] OP_CPU_READ   = 3'd0;
	localparam logic [OpWidth-1:0] OP_CPU_WRITE  = 3'd1;
	localparam logic [OpWidth-1:0] OP_BANK_WRITE = 3'd2;
	localparam logic [OpWidth-1:0] OP_SCROLL_WR  = 3'd3;
	localparam logic [OpWidth-1:0] OP_TILE_FETCH = 3'd4;

	localparam logic [ColorWidth-1:0] BG_FORCED_COLOR = 3'd6;
	localparam logic [ColorWidth-1:0] FG_FORCED_COLOR = 3'd7;
	localparam logic [4:0] FG_OPAQUE_COLS = 5'd3;

	typedef struct packed {
		logic [OpWidth-1:0]   op;
		logic [TileWidth-1:0] tile_pos;
		logic                 layer;
	} req_info_t;

	typedef struct packed {
		logic [ByteWidth-1:0]  read_data;
		logic [CodeWidth-1:0]  char_code;
		logic [ColorWidth-1:0] colour;
		logic                  opaque;
		logic [ByteWidth-1:0]  scroll_x;
	} result_t;

endpackage

FILE: sv/btrad_attr_dec.sv
// ----------------------------------------------------------------------------
// Tile attribute decoder
// Turns the byte read from video RAM into the result of a request: the CPU
// read byte, or the character code, color and opaque flag of a tile fetch, plus the scroll.
// ----------------------------------------------------------------------------
module btrad_attr_dec (
	input  btrad_pkg::req_info_t             info,
	input  logic [btrad_pkg::ByteWidth-1:0]  ram_byte,
	input  logic [btrad_pkg::ByteWidth-1:0]  scroll,
	output btrad_pkg::result_t               result
);
	import btrad_pkg::*;

	logic [TileWidth-1:0]  ti;
	logic                  bg_low;
	logic [ColorWidth-1:0] bg_color;
	logic [ColorWidth-1:0] fg_color;

	assign ti = info.tile_pos;

	always_comb begin
		bg_low = !ti[2] || (!ti[8] && ti[7:6] == 2'b10) || (ti[8] && ti[7:6] != 2'b00);
		bg_color = {1'b0, ti[2], bg_low};
		fg_color = {~ti[2], ti[2:1]};
	end

	always_comb begin
		result = '0;
		result.scroll_x = scroll;
		case (info.op)
			OP_CPU_READ: begin
				result.read_data = ram_byte;
			end
			OP_TILE_FETCH: begin
				result.char_code = ram_byte[CodeWidth-1:0];
				if (!info.layer) begin
					result.colour = ram_byte[ByteWidth-1] ? BG_FORCED_COLOR : bg_color;
					result.opaque = 1'b1;
				end else begin
					result.colour = ram_byte[ByteWidth-1] ? FG_FORCED_COLOR : fg_color;
					result.opaque = (ti[4:0] < FG_OPAQUE_COLS);
				end
			end
			default: begin
				result.read_data = '0;
			end
		endcase
	end

endmodule

FILE: sv/banked_tile_ram_attribute_decoder_top.sv
// ----------------------------------------------------------------------------
// Banked tile RAM attribute decoder
// Two 2 KiB video RAM banks held in one single-port synchronous RAM, with a
// bank select, a background scroll register and tile attribute decoding.
// ----------------------------------------------------------------------------
// Each request makes one access to the single-port video RAM at its accept
// edge; the read byte is registered in the RAM read stage, and the decoded
// result is then registered at the master side, where it can be taken; with
// the master side draining, a new request is taken every cycle.
// A result that waits on the master side holds one further request in the
// RAM read stage, after which the slave side stalls. The RAM contents are
// undefined after reset and need no clearing pass.
module banked_tile_ram_attribute_decoder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata fields from bit 0: op, address, data, tile_pos, layer, zero fill.
	input  logic [btrad_pkg::InWidth-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata fields from bit 0: read_data, char_code, colour, opaque, scroll_x,
	// zero fill.
	output logic [btrad_pkg::OutWidth-1:0]  m_tdata
);
	import btrad_pkg::*;

	logic [OpWidth-1:0]      req_op;
	logic [AddrWidth-1:0]    req_address;
	logic [ByteWidth-1:0]    req_data;
	logic [TileWidth-1:0]    req_tile;
	logic                    req_layer;

	logic                    accept;
	logic                    advance;
	logic [RamAddrWidth-1:0] ram_addr;

	logic [ByteWidth-1:0]    vram_mem [RamDepth];
	logic [ByteWidth-1:0]    rdata_s1;
	req_info_t               info_s1;
	logic                    valid_s1;

	logic                    bank_q;
	logic [ByteWidth-1:0]    scroll_q;
	logic                    m_valid_q;
	result_t                 result;
	result_t                 result_q;

	assign req_op      = s_tdata[2:0];
	assign req_address = s_tdata[13:3];
	assign req_data    = s_tdata[21:14];
	assign req_tile    = s_tdata[31:22];
	assign req_layer   = s_tdata[32];

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (req_op == OP_TILE_FETCH) begin
			ram_addr = {bank_q, ~req_layer, req_tile};
		end else begin
			ram_addr = {bank_q, req_address};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_op == OP_CPU_WRITE) begin
				vram_mem[ram_addr] <= req_data;
			end else begin
				rdata_s1 <= vram_mem[ram_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1.op       <= req_op;
			info_s1.tile_pos <= req_tile;
			info_s1.layer    <= req_layer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 1'b0;
			scroll_q <= '0;
		end else if (accept) begin
			if (req_op == OP_BANK_WRITE) begin
				bank_q <= req_data[0];
			end
			if (req_op == OP_SCROLL_WR) begin
				scroll_q <= req_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	btrad_attr_dec u_attr_dec (
		.info     (info_s1),
		.ram_byte (rdata_s1),
		.scroll   (scroll_q),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, result_q.scroll_x, result_q.opaque, result_q.colour,
		result_q.char_code, result_q.read_data};

`include "banked_tile_ram_attribute_decoder_top_assert.svh"

	`BTRAD_ASSERT_SAME(a_stall_blocks_input, valid_s1 && !advance, !s_tready, "Request accepted while the RAM read stage is stalled.")
	`BTRAD_ASSERT_NEXT(a_accept_fills_s1, accept, valid_s1, "Accepted request did not reach the RAM read stage.")
	`BTRAD_ASSERT_NEXT(a_bank_only_on_request, !(accept && req_op == OP_BANK_WRITE), $stable(bank_q), "Bank select changed without a bank select request.")
	`BTRAD_ASSERT_NEXT(a_result_loaded, advance, m_valid_q, "Advanced request did not produce a result.")

endmodule
